/* hw/rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LIST       = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // what every cell does this cycle
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_SHIFT_LEFT = 3'd3,
        OP_ROTATE     = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic signed [WORD_W-1:0] value;
    } cell_cmd_t;

endpackage

/* hw/rtl/double_ended_queue_top.sv */
`timescale 1ns / 1ps
// channel  dir  tdata          tuser       tlast
// s_*      in   [31:0] value   [2:0] action  -
// m_*      out  [31:0] data    [1:0] status  last
//
// Push and pop: one word in, one word out; the next word is taken once the output is free.
// List of n words: n result words, input held off until the last one goes out.
// The words live in a row of DEPTH cells, front in cell 0; list rotates the row
// once around. rst_n clears count, list state and the output valid flag.
// A stalled output holds its word and blocks input.

module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [deq_pkg::WORD_W-1:0]   s_tdata,  // value
    input  logic [deq_pkg::ACT_W-1:0]           s_tuser,  // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [deq_pkg::WORD_W-1:0]   m_tdata,  // data
    output logic [deq_pkg::STAT_W-1:0]          m_tuser,  // status
    output logic                                m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    idx_reg, idx_next;
    logic                                valid_reg, valid_next;
    logic [deq_pkg::STAT_W-1:0]          status_reg, status_next;
    logic signed [deq_pkg::WORD_W-1:0]   data_reg, data_next;
    logic                                last_reg, last_next;

    deq_pkg::cell_cmd_t                  cmd;
    logic signed [deq_pkg::WORD_W-1:0]   cell_data [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0]   cell_tap  [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0]   back_data;
    logic                                out_free;
    logic                                accept;
    logic                                full;
    logic                                empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [deq_pkg::WORD_W-1:0] left_w;
            logic signed [deq_pkg::WORD_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            deq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .count (count_reg),
                .left  (left_w),
                .right (right_w),
                .head  (cell_data[0]),
                .data  (cell_data[g]),
                .tap   (cell_tap[g])
            );
        end
    endgenerate

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tap[i];
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !m_tready;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        cmd.op      = deq_pkg::OP_HOLD;
        cmd.value   = s_tdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (deq_pkg::action_t'(s_tuser))
                        deq_pkg::ACT_PUSH_FRONT,
                        deq_pkg::ACT_PUSH_BACK:
                        begin
                            valid_next = 1'b1;
                            data_next  = '0;
                            last_next  = 1'b1;
                            if (full)
                            begin
                                status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                status_next = deq_pkg::STAT_OK;
                                count_next  = count_reg + 1'b1;
                                cmd.op = (s_tuser == deq_pkg::ACT_PUSH_FRONT) ?
                                         deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
                            end
                        end
                        deq_pkg::ACT_POP_FRONT,
                        deq_pkg::ACT_POP_BACK:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                                data_next   = '0;
                            end
                            else
                            begin
                                status_next = deq_pkg::STAT_OK;
                                count_next  = count_reg - 1'b1;
                                if (s_tuser == deq_pkg::ACT_POP_FRONT)
                                begin
                                    data_next = cell_data[0];
                                    cmd.op    = deq_pkg::OP_SHIFT_LEFT;
                                end
                                else
                                begin
                                    data_next = back_data;
                                end
                            end
                        end
                        deq_pkg::ACT_LIST:
                        begin
                            valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                                data_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                status_next = deq_pkg::STAT_OK;
                                data_next   = cell_data[0];
                                last_next   = (count_reg == CNT_W'(1));
                                cmd.op      = deq_pkg::OP_ROTATE;
                                idx_next    = CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = S_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            valid_next = valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    valid_next  = 1'b1;
                    status_next = deq_pkg::STAT_OK;
                    data_next   = cell_data[0];
                    last_next   = (idx_reg + 1'b1 == count_reg);
                    cmd.op      = deq_pkg::OP_ROTATE;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

/* hw/rtl/deq_cell.sv */
`timescale 1ns / 1ps

module deq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                             clk,
    input  deq_pkg::cell_cmd_t               cmd,
    input  logic [CNT_W-1:0]                 count,
    input  logic signed [deq_pkg::WORD_W-1:0] left,
    input  logic signed [deq_pkg::WORD_W-1:0] right,
    input  logic signed [deq_pkg::WORD_W-1:0] head,
    output logic signed [deq_pkg::WORD_W-1:0] data,
    output logic signed [deq_pkg::WORD_W-1:0] tap
);

    logic signed [deq_pkg::WORD_W-1:0] data_reg;
    logic signed [deq_pkg::WORD_W-1:0] data_next;
    logic                              is_tail;
    logic                              is_back;

    assign is_tail = (CNT_W'(IDX) == count);
    assign is_back = (CNT_W'(IDX + 1) == count);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            deq_pkg::OP_HOLD:       data_next = data_reg;
            deq_pkg::OP_PUSH_FRONT: data_next = (IDX == 0) ? cmd.value : left;
            deq_pkg::OP_PUSH_BACK:  data_next = is_tail ? cmd.value : data_reg;
            deq_pkg::OP_SHIFT_LEFT: data_next = right;
            deq_pkg::OP_ROTATE:     data_next = is_back ? head : right;
            default:                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = is_back ? data_reg : '0;

endmodule
